// ===== rtl/core/symmetric_coo_to_csr_converter_core_defines.svh =====
// Assertion macros used by the converter core.
`ifndef SYMMETRIC_COO_TO_CSR_CONVERTER_CORE_DEFINES_SVH
`define SYMMETRIC_COO_TO_CSR_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SCSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCSR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/scsr_pkg.sv =====
`default_nettype none
package scsr_pkg;
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_LOADED   = 4096;
    localparam int MAX_EXPANDED = 8192;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int RC_W    = ROW_W + 1;
    localparam int OFFS_AW = $clog2(MAX_ROWS + 1);
    localparam int LOAD_AW = $clog2(MAX_LOADED);
    localparam int LOAD_CW = LOAD_AW + 1;
    localparam int EXP_AW  = $clog2(MAX_EXPANDED);
    localparam int EXP_W   = EXP_AW + 1;
    localparam int VAL_W   = 64;
    localparam int IDX_W   = 14;
    localparam int STAT_W  = 3;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ROWSTART = 2'd2;
    localparam logic [ACT_W-1:0] ACT_ENTRY    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_COORD = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [EXP_W-1:0]  row_start;
        logic [ROW_W-1:0]  entry_col;
        logic [VAL_W-1:0]  entry_value;
        logic [EXP_W-1:0]  total_entries;
    } t_rsp;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_coord;

    typedef struct packed {
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_pentry;
endpackage
`default_nettype wire

// ===== rtl/core/scsr_coord_store.sv =====
`default_nettype none
module scsr_coord_store import scsr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [LOAD_AW-1:0] i_waddr,
    input  t_coord             i_wdata,
    input  logic [LOAD_AW-1:0] i_raddr,
    output t_coord             o_rdata
);
    t_coord r_mem [MAX_LOADED];
    t_coord r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/scsr_packed_store.sv =====
`default_nettype none
module scsr_packed_store import scsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [EXP_AW-1:0] i_waddr,
    input  t_pentry           i_wdata,
    input  logic [EXP_AW-1:0] i_raddr,
    output t_pentry           o_rdata
);
    t_pentry r_mem [MAX_EXPANDED];
    t_pentry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/symmetric_coo_to_csr_converter_core.sv =====
`default_nettype none
// Load, read-row-start and read-entry items: result in the cycle after accept; no new item is taken before it shows.
// Build item: passes over the rows in use, the loaded entries and the expanded entries.
// Results show for one cycle on o_done; the receiver cannot stall.
// Synchronous active-low reset: 1024 rows, nothing loaded, not built; stores keep content.
`include "symmetric_coo_to_csr_converter_core_defines.svh"
module symmetric_coo_to_csr_converter_core import scsr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_cmd            i_cmd,
    output logic            o_done,
    output t_rsp            o_rsp,
    input  logic            i_cfg_we,
    input  logic [RC_W-1:0] i_cfg_wdata
);
    // One-hot sequencer. The build runs five passes:
    //   clear counts, count rows (with mirrors), prefix sum,
    //   scatter by column into the middle store, scatter by row into packed store.
    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_RESP   = 16'b0000_0000_0000_0010,
        S_CLR    = 16'b0000_0000_0000_0100,
        S_CRD    = 16'b0000_0000_0000_1000,
        S_CK     = 16'b0000_0000_0001_0000,
        S_CW1    = 16'b0000_0000_0010_0000,
        S_CW2    = 16'b0000_0000_0100_0000,
        S_PFX_RD = 16'b0000_0000_1000_0000,
        S_PFX_WR = 16'b0000_0001_0000_0000,
        S_SRD    = 16'b0000_0010_0000_0000,
        S_SK     = 16'b0000_0100_0000_0000,
        S_SW1    = 16'b0000_1000_0000_0000,
        S_SW2    = 16'b0001_0000_0000_0000,
        S_RRD    = 16'b0010_0000_0000_0000,
        S_RK     = 16'b0100_0000_0000_0000,
        S_RW     = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [RC_W-1:0]    r_row_count, n_row_count;
    logic [LOAD_CW-1:0] r_loaded, n_loaded;
    logic [EXP_W-1:0]   r_expanded, n_expanded;
    logic               r_built, n_built;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [ACT_W-1:0]   r_act, n_act;
    logic [LOAD_CW-1:0] r_i, n_i;
    logic [RC_W-1:0]    r_j, n_j;
    logic [EXP_W-1:0]   r_k, n_k;
    logic [EXP_W:0]     r_total, n_total;
    logic [EXP_W-1:0]   r_run, n_run;
    logic [ROW_W-1:0]   r_er, n_er;
    logic [ROW_W-1:0]   r_ec, n_ec;
    logic [VAL_W-1:0]   r_ev, n_ev;

    // memory controls
    logic               coord_we;
    t_coord             coord_wdata, coord_q;
    logic               cnt_we;
    logic [ROW_W-1:0]   cnt_waddr, cnt_raddr;
    logic [EXP_W-1:0]   cnt_wdata, r_cnt_q;
    logic               fill_we;
    logic [ROW_W-1:0]   fill_waddr;
    logic [EXP_W-1:0]   fill_wdata, r_fill_q;
    logic               offs_we;
    logic [OFFS_AW-1:0] offs_waddr;
    logic [EXP_W-1:0]   offs_wdata, r_offs_q;
    logic               mid_we;
    logic [EXP_AW-1:0]  mid_waddr;
    t_coord             mid_wdata, r_mid_q;
    logic               pk_we;
    logic [EXP_AW-1:0]  pk_waddr;
    t_pentry            pk_wdata, pk_q;
    logic               coord_ok;

    logic [EXP_W-1:0] r_cnt_mem  [MAX_ROWS];
    logic [EXP_W-1:0] r_fill_mem [MAX_ROWS];
    logic [EXP_W-1:0] r_offs_mem [MAX_ROWS + 1];
    t_coord           r_mid_mem  [MAX_EXPANDED];

    scsr_coord_store u_coord (
        .i_clk   (i_clk),
        .i_we    (coord_we),
        .i_waddr (r_loaded[LOAD_AW-1:0]),
        .i_wdata (coord_wdata),
        .i_raddr (r_i[LOAD_AW-1:0]),
        .o_rdata (coord_q)
    );

    scsr_packed_store u_packed (
        .i_clk   (i_clk),
        .i_we    (pk_we),
        .i_waddr (pk_waddr),
        .i_wdata (pk_wdata),
        .i_raddr (i_cmd.index[EXP_AW-1:0]),
        .o_rdata (pk_q)
    );

    // Count, fill, offset and middle stores; reads are registered.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= r_cnt_mem[cnt_raddr];
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_q <= r_fill_mem[r_mid_q.row];
        if (offs_we) begin
            r_offs_mem[offs_waddr] <= offs_wdata;
        end
        r_offs_q <= r_offs_mem[i_cmd.index[OFFS_AW-1:0]];
        if (mid_we) begin
            r_mid_mem[mid_waddr] <= mid_wdata;
        end
        r_mid_q <= r_mid_mem[r_k[EXP_AW-1:0]];
    end

    // A stored coordinate is live only while inside the current row count.
    assign coord_ok = ({1'b0, coord_q.row} < r_row_count) &&
                      ({1'b0, coord_q.col} < r_row_count);

    always_comb begin
        n_state     = r_state;
        n_row_count = r_row_count;
        n_loaded    = r_loaded;
        n_expanded  = r_expanded;
        n_built     = r_built;
        n_status    = r_status;
        n_act       = r_act;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_total     = r_total;
        n_run       = r_run;
        n_er        = r_er;
        n_ec        = r_ec;
        n_ev        = r_ev;

        coord_we    = 1'b0;
        coord_wdata = '{row: i_cmd.row, col: i_cmd.col, value: i_cmd.value};
        cnt_we      = 1'b0;
        cnt_waddr   = r_j[ROW_W-1:0];
        cnt_wdata   = r_run;
        cnt_raddr   = r_j[ROW_W-1:0];
        fill_we     = 1'b0;
        fill_waddr  = r_j[ROW_W-1:0];
        fill_wdata  = r_run;
        offs_we     = 1'b0;
        offs_waddr  = r_j[OFFS_AW-1:0];
        offs_wdata  = r_run;
        mid_we      = 1'b0;
        mid_waddr   = r_cnt_q[EXP_AW-1:0];
        mid_wdata   = '{row: r_er, col: r_ec, value: r_ev};
        pk_we       = 1'b0;
        pk_waddr    = r_fill_q[EXP_AW-1:0];
        pk_wdata    = '{col: r_ec, value: r_ev};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act   = i_cmd.action;
                    n_state = S_RESP;
                    case (i_cmd.action)
                        ACT_LOAD: begin
                            if (({1'b0, i_cmd.row} >= r_row_count) ||
                                ({1'b0, i_cmd.col} >= r_row_count)) begin
                                n_status = ST_BAD_COORD;
                            end else if (r_loaded == LOAD_CW'(MAX_LOADED)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                coord_we = 1'b1;
                                n_loaded = r_loaded + 1'b1;
                                n_built  = 1'b0;
                            end
                        end
                        ACT_BUILD: begin
                            n_j     = '0;
                            n_state = S_CLR;
                        end
                        ACT_ROWSTART: begin
                            if (!r_built) begin
                                n_status = ST_NOT_BUILT;
                            end else if (i_cmd.index > IDX_W'(r_row_count)) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_status = ST_OK;
                            end
                        end
                        ACT_ENTRY: begin
                            if (!r_built) begin
                                n_status = ST_NOT_BUILT;
                            end else if (i_cmd.index >= r_expanded) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_status = ST_OK;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            // clear one count per cycle over the rows in use
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                if (r_j == r_row_count - 1'b1) begin
                    n_i     = '0;
                    n_total = '0;
                    n_state = S_CRD;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_CRD: begin
                if (r_i == r_loaded) begin
                    if (r_total > (EXP_W + 1)'(MAX_EXPANDED)) begin
                        n_status   = ST_FULL;
                        n_built    = 1'b0;
                        n_expanded = '0;
                        n_state    = S_RESP;
                    end else begin
                        n_j     = '0;
                        n_run   = '0;
                        n_state = S_PFX_RD;
                    end
                end else begin
                    n_state = S_CK;
                end
            end
            S_CK: begin
                n_i = r_i + 1'b1;
                if (coord_ok) begin
                    n_er      = coord_q.row;
                    n_ec      = coord_q.col;
                    cnt_raddr = coord_q.row;
                    n_total   = r_total + ((coord_q.row != coord_q.col) ?
                                (EXP_W + 1)'(2) : (EXP_W + 1)'(1));
                    n_state   = S_CW1;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_CW1: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_er;
                cnt_wdata = r_cnt_q + 1'b1;
                if (r_er != r_ec) begin
                    cnt_raddr = r_ec;
                    n_state   = S_CW2;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_CW2: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_ec;
                cnt_wdata = r_cnt_q + 1'b1;
                n_state   = S_CRD;
            end
            // exclusive prefix sum: counts become write pointers
            S_PFX_RD: begin
                if (r_j == r_row_count) begin
                    offs_we = 1'b1;
                    n_i     = '0;
                    n_state = S_SRD;
                end else begin
                    n_state = S_PFX_WR;
                end
            end
            S_PFX_WR: begin
                cnt_we  = 1'b1;
                fill_we = 1'b1;
                offs_we = 1'b1;
                n_run   = r_run + r_cnt_q;
                n_j     = r_j + 1'b1;
                n_state = S_PFX_RD;
            end
            S_SRD: begin
                if (r_i == r_loaded) begin
                    n_k     = '0;
                    n_state = S_RRD;
                end else begin
                    n_state = S_SK;
                end
            end
            S_SK: begin
                n_i = r_i + 1'b1;
                if (coord_ok) begin
                    n_er      = coord_q.row;
                    n_ec      = coord_q.col;
                    n_ev      = coord_q.value;
                    cnt_raddr = coord_q.col;
                    n_state   = S_SW1;
                end else begin
                    n_state = S_SRD;
                end
            end
            // own copy goes into its column bucket
            S_SW1: begin
                mid_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = r_ec;
                cnt_wdata = r_cnt_q + 1'b1;
                if (r_er != r_ec) begin
                    cnt_raddr = r_er;
                    n_state   = S_SW2;
                end else begin
                    n_state = S_SRD;
                end
            end
            // mirror copy follows the own copy
            S_SW2: begin
                mid_we    = 1'b1;
                mid_wdata = '{row: r_ec, col: r_er, value: r_ev};
                cnt_we    = 1'b1;
                cnt_waddr = r_er;
                cnt_wdata = r_cnt_q + 1'b1;
                n_state   = S_SRD;
            end
            S_RRD: begin
                if ({1'b0, r_k} == r_total) begin
                    n_built    = 1'b1;
                    n_expanded = r_total[EXP_W-1:0];
                    n_status   = ST_OK;
                    n_state    = S_RESP;
                end else begin
                    n_state = S_RK;
                end
            end
            S_RK: begin
                n_er    = r_mid_q.row;
                n_ec    = r_mid_q.col;
                n_ev    = r_mid_q.value;
                n_k     = r_k + 1'b1;
                n_state = S_RW;
            end
            S_RW: begin
                pk_we      = 1'b1;
                fill_we    = 1'b1;
                fill_waddr = r_er;
                fill_wdata = r_fill_q + 1'b1;
                n_state    = S_RRD;
            end
            default: n_state = S_IDLE;
        endcase

        // clamp the row count; any write drops the built matrix
        if (i_cfg_we) begin
            n_built = 1'b0;
            if (i_cfg_wdata == '0) begin
                n_row_count = RC_W'(1);
            end else if (i_cfg_wdata > RC_W'(MAX_ROWS)) begin
                n_row_count = RC_W'(MAX_ROWS);
            end else begin
                n_row_count = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= RC_W'(MAX_ROWS);
            r_loaded    <= '0;
            r_expanded  <= '0;
            r_built     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_count <= n_row_count;
            r_loaded    <= n_loaded;
            r_expanded  <= n_expanded;
            r_built     <= n_built;
        end
        r_status <= n_status;
        r_act    <= n_act;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_total  <= n_total;
        r_run    <= n_run;
        r_er     <= n_er;
        r_ec     <= n_ec;
        r_ev     <= n_ev;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

    always_comb begin
        o_rsp.status        = r_status;
        o_rsp.row_start     = ((r_act == ACT_ROWSTART) && (r_status == ST_OK)) ?
                              r_offs_q : '0;
        o_rsp.entry_col     = ((r_act == ACT_ENTRY) && (r_status == ST_OK)) ?
                              pk_q.col : '0;
        o_rsp.entry_value   = ((r_act == ACT_ENTRY) && (r_status == ST_OK)) ?
                              pk_q.value : '0;
        o_rsp.total_entries = r_built ? r_expanded : '0;
    end

    `SCSR_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept did not raise busy")
    `SCSR_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |=> !busy, "no return to idle after result")
    `SCSR_ASSERT(a_total_built, i_clk, i_rst_n, (o_done && (o_rsp.total_entries != '0)) |-> r_built, "total shown while not built")
    `SCSR_ASSERT(a_loaded_cap, i_clk, i_rst_n, r_loaded <= LOAD_CW'(MAX_LOADED), "loaded count overflow")
endmodule
`default_nettype wire

// ===== bench/scsr_checker.sv =====
`timescale 1ns / 1ps
// Watches the command and result channels, predicts each result from its own
// copy of the converter state and compares every field.
module scsr_checker import scsr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  t_cmd            i_cmd,
    input  logic            o_done,
    input  t_rsp            o_rsp,
    input  logic            i_cfg_we,
    input  logic [RC_W-1:0] i_cfg_wdata,
    output int              fail_count,
    output int              pending,
    output int              loaded_now,
    output int              expanded_now
);
    // Predicted converter state
    int        rows_in_use;
    int        n_loaded;
    int        n_expanded;
    bit        is_built;
    int        coo_row [MAX_LOADED];
    int        coo_col [MAX_LOADED];
    bit [63:0] coo_val [MAX_LOADED];
    int        row_base[MAX_ROWS+1];
    int        csr_col [MAX_EXPANDED];
    bit [63:0] csr_val [MAX_EXPANDED];

    // Scratch for the two stable bucket passes
    int        seq_row[MAX_EXPANDED];
    int        seq_col[MAX_EXPANDED];
    bit [63:0] seq_val[MAX_EXPANDED];
    int        mid_row[MAX_EXPANDED];
    int        mid_col[MAX_EXPANDED];
    bit [63:0] mid_val[MAX_EXPANDED];
    int        bkt    [MAX_ROWS+1];
    int        fill   [MAX_ROWS];

    t_rsp expected_rsps[$];

    assign pending      = expected_rsps.size();
    assign loaded_now   = n_loaded;
    assign expanded_now = is_built ? n_expanded : 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Expand mirrors, then stable sort by column and by row.
    function automatic logic [STAT_W-1:0] compress_rows();
        int total;
        int n;
        int p;
        total = 0;
        for (int i = 0; i < n_loaded; i++) begin
            if (coo_row[i] < rows_in_use && coo_col[i] < rows_in_use)
                total += (coo_row[i] != coo_col[i]) ? 2 : 1;
        end
        if (total > MAX_EXPANDED) begin
            is_built   = 0;
            n_expanded = 0;
            return ST_FULL;
        end
        n = 0;
        for (int i = 0; i < n_loaded; i++) begin
            if (coo_row[i] >= rows_in_use || coo_col[i] >= rows_in_use) continue;
            seq_row[n] = coo_row[i]; seq_col[n] = coo_col[i]; seq_val[n] = coo_val[i]; n++;
            if (coo_row[i] != coo_col[i]) begin
                seq_row[n] = coo_col[i]; seq_col[n] = coo_row[i]; seq_val[n] = coo_val[i];
                n++;
            end
        end
        for (int i = 0; i <= MAX_ROWS; i++) bkt[i] = 0;
        for (int i = 0; i < n; i++) bkt[seq_col[i] + 1]++;
        for (int i = 1; i <= rows_in_use; i++) bkt[i] += bkt[i-1];
        for (int i = 0; i < n; i++) begin
            p = bkt[seq_col[i]]++;
            mid_row[p] = seq_row[i]; mid_col[p] = seq_col[i]; mid_val[p] = seq_val[i];
        end
        for (int i = 0; i <= MAX_ROWS; i++) bkt[i] = 0;
        for (int i = 0; i < n; i++) bkt[mid_row[i]]++;
        row_base[0] = 0;
        for (int i = 0; i < rows_in_use; i++) begin
            row_base[i+1] = row_base[i] + bkt[i];
            fill[i]       = row_base[i];
        end
        for (int i = 0; i < n; i++) begin
            p = fill[mid_row[i]]++;
            csr_col[p] = mid_col[i];
            csr_val[p] = mid_val[i];
        end
        n_expanded = n;
        is_built   = 1;
        return ST_OK;
    endfunction

    function automatic t_rsp predict_rsp(input t_cmd c);
        t_rsp r;
        r = '0;
        r.status = ST_OK;
        case (c.action)
            ACT_LOAD: begin
                if (c.row >= rows_in_use || c.col >= rows_in_use) begin
                    r.status = ST_BAD_COORD;
                end else if (n_loaded >= MAX_LOADED) begin
                    r.status = ST_FULL;
                end else begin
                    coo_row[n_loaded] = c.row;
                    coo_col[n_loaded] = c.col;
                    coo_val[n_loaded] = c.value;
                    n_loaded++;
                    is_built = 0;
                end
            end
            ACT_BUILD: r.status = compress_rows();
            default: begin
                if (!is_built) begin
                    r.status = ST_NOT_BUILT;
                end else if (c.action == ACT_ROWSTART) begin
                    if (c.index > rows_in_use) r.status = ST_BAD_INDEX;
                    else r.row_start = EXP_W'(row_base[c.index]);
                end else begin
                    if (c.index >= n_expanded) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        r.entry_col   = ROW_W'(csr_col[c.index]);
                        r.entry_value = csr_val[c.index];
                    end
                end
            end
        endcase
        r.total_entries = is_built ? EXP_W'(n_expanded) : '0;
        return r;
    endfunction

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_rsp want;
        int   v;
        if (!i_rst_n) begin
            rows_in_use = MAX_ROWS;
            n_loaded    = 0;
            n_expanded  = 0;
            is_built    = 0;
            expected_rsps.delete();
        end else begin
            // results first: a result never belongs to the item accepted on this edge
            if (o_done) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: result with no item waiting", $realtime);
                    fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.status !== want.status)
                        report("status", o_rsp.status, want.status);
                    if (o_rsp.row_start !== want.row_start)
                        report("row_start", o_rsp.row_start, want.row_start);
                    if (o_rsp.entry_col !== want.entry_col)
                        report("entry_col", o_rsp.entry_col, want.entry_col);
                    if (o_rsp.entry_value !== want.entry_value)
                        report("entry_value", o_rsp.entry_value, want.entry_value);
                    if (o_rsp.total_entries !== want.total_entries)
                        report("total_entries", o_rsp.total_entries, want.total_entries);
                end
            end
            if (start && !busy) expected_rsps.push_back(predict_rsp(i_cmd));
            if (i_cfg_we) begin
                v = i_cfg_wdata;
                if (v == 0) v = 1;
                if (v > MAX_ROWS) v = MAX_ROWS;
                rows_in_use = v;
                is_built    = 0;
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import scsr_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     ITEM_GOAL   = 1300;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_cmd            i_cmd;
    logic            o_done;
    t_rsp            o_rsp;
    logic            i_cfg_we;
    logic [RC_W-1:0] i_cfg_wdata;

    int     fail_count;
    int     pending;
    int     loaded_now;
    int     expanded_now;
    longint cycle_count;

    // Stimulus bookkeeping
    int rows_set;
    int n_items;
    int n_loads;
    int n_builds;
    int n_start_reads;
    int n_entry_reads;
    int n_settings;
    bit no_gaps;

    symmetric_coo_to_csr_converter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    scsr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_done       (o_done),
        .o_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .loaded_now   (loaded_now),
        .expanded_now (expanded_now)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: a build over a full store is the slowest item by far.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one item after a random gap and hold it until the core takes it.
    // Leave start high on return so back-to-back items need no extra toggle.
    task automatic send(input t_cmd c);
        int  gap;
        bit  taken;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        n_items++;
        case (c.action)
            ACT_LOAD:     n_loads++;
            ACT_BUILD:    n_builds++;
            ACT_ROWSTART: n_start_reads++;
            default:      n_entry_reads++;
        endcase
    endtask

    // Drop start and hold until every item has answered.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the row count; the core must be idle.
    task automatic set_rows(input logic [RC_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rows_set = (v == 0) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
        n_settings++;
    endtask

    function automatic t_cmd make_cmd(input logic [ACT_W-1:0] act, input int r, input int c,
                                      input logic [63:0] v, input int idx);
        t_cmd m;
        m.action = act;
        m.row    = ROW_W'(r);
        m.col    = ROW_W'(c);
        m.value  = v;
        m.index  = IDX_W'(idx);
        return m;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly in-range coordinates, some diagonal, a few out of range.
    function automatic t_cmd rand_load();
        int r;
        int c;
        r = $urandom_range(0, rows_set - 1);
        c = ($urandom_range(0, 4) == 0) ? r : $urandom_range(0, rows_set - 1);
        if (rows_set < MAX_ROWS && $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) r = $urandom_range(rows_set, 1023);
            else c = $urandom_range(rows_set, 1023);
        end
        return make_cmd(ACT_LOAD, r, c, rand_word(), $urandom_range(0, 16383));
    endfunction

    // Reads mostly within range, sometimes anywhere in the index field; a few loads and builds mixed in.
    function automatic t_cmd rand_read();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        if (sel < 5) return rand_load();
        if (sel < 9) return make_cmd(ACT_BUILD, $urandom, $urandom, rand_word(), $urandom);
        if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 16383);
        else if (sel < 54) idx = $urandom_range(0, rows_set + 1);
        else idx = $urandom_range(0, expanded_now);
        return make_cmd((sel < 54) ? ACT_ROWSTART : ACT_ENTRY, $urandom, $urandom,
                        rand_word(), idx);
    endfunction

    initial begin
        int settings[$];
        int nl;
        int nr;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        rows_set    = MAX_ROWS;
        n_items = 0; n_loads = 0; n_builds = 0;
        n_start_reads = 0; n_entry_reads = 0; n_settings = 0;
        no_gaps = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads before any build, an empty build, field extremes.
        send(make_cmd(ACT_ROWSTART, 0, 0, '0, 0));
        send(make_cmd(ACT_ENTRY, 0, 0, '0, 0));
        send(make_cmd(ACT_BUILD, 0, 0, '0, 0));
        send(make_cmd(ACT_ROWSTART, 0, 0, '0, 0));
        send(make_cmd(ACT_ROWSTART, 0, 0, '0, MAX_ROWS));
        send(make_cmd(ACT_ROWSTART, 0, 0, '0, MAX_ROWS + 1));
        send(make_cmd(ACT_ROWSTART, 1023, 1023, '1, 16383));
        send(make_cmd(ACT_ENTRY, 0, 0, '0, 0));
        send(make_cmd(ACT_LOAD, 0, 0, '1, 0));
        send(make_cmd(ACT_LOAD, 1023, 1023, '0, 16383));
        send(make_cmd(ACT_LOAD, 1023, 0, 64'h8000_0000_0000_0001, 0));
        send(make_cmd(ACT_LOAD, 5, 700, 64'h0123_4567_89AB_CDEF, 0));
        send(make_cmd(ACT_LOAD, 700, 5, 64'hFEDC_BA98_7654_3210, 0));
        send(make_cmd(ACT_ENTRY, 0, 0, '0, 0));
        send(make_cmd(ACT_BUILD, 0, 0, '0, 0));
        for (int i = 0; i < 8; i++) send(make_cmd(ACT_ENTRY, 0, 0, '0, i));
        send(make_cmd(ACT_ROWSTART, 0, 0, '0, MAX_ROWS));
        send(make_cmd(ACT_ROWSTART, 0, 0, '0, 5));

        // Random phases: new row count, loads, build, then mixed reads.
        // Extremes first, then mostly small matrices so rows collide often.
        settings = '{0, 2047, 1, 2, 1024};
        while (n_items < ITEM_GOAL) begin
            if (settings.size() != 0) set_rows(RC_W'(settings.pop_front()));
            else if ($urandom_range(0, 4) == 0) set_rows(RC_W'($urandom_range(0, 2047)));
            else set_rows(RC_W'($urandom_range(2, 64)));
            no_gaps = ($urandom_range(0, 3) == 0);
            nl = $urandom_range(5, 50);
            nr = $urandom_range(20, 60);
            for (int i = 0; i < nl; i++) send(rand_load());
            if ($urandom_range(0, 1)) send(make_cmd(ACT_ROWSTART, 0, 0, '0, 0));
            send(make_cmd(ACT_BUILD, $urandom, $urandom, rand_word(), $urandom));
            for (int i = 0; i < nr; i++) send(rand_read());
        end

        // Rebuild everything loaded at the full row count and read back.
        set_rows(RC_W'(MAX_ROWS));
        send(make_cmd(ACT_BUILD, 0, 0, '0, 0));
        for (int i = 0; i < 30; i++) send(rand_read());
        send(make_cmd(ACT_ENTRY, 0, 0, '0, MAX_EXPANDED - 1));

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d loads, %0d builds, %0d row-start reads, %0d entry reads",
                 n_loads, n_builds, n_start_reads, n_entry_reads);
        $display("across %0d row-count settings, ending with %0d entries held in store",
                 n_settings, loaded_now);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
